>>> sv/mde_pkg.sv
// Package for the maze explorer: types, codes and helper functions.
// No dependencies; mde_front, mde_back and the top level import it.
package mde_pkg;

	localparam int MAZE_SIDE_DEF = 16;
	localparam int STACK_DEPTH_DEF = 256;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_START_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_HEADING = 2'd2;

	typedef enum logic [2:0] {
		ST_MOVE = 3'd0,
		ST_DEAD = 3'd1,
		ST_BACK_ON = 3'd2,
		ST_BACK_END = 3'd3,
		ST_GOAL = 3'd4,
		ST_EMPTY = 3'd5,
		ST_REFUSED = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		MODE_EXPLORE = 2'd0,
		MODE_BACK = 2'd1,
		MODE_GOAL = 2'd2,
		MODE_HALT = 2'd3
	} mode_t;

	localparam logic [1:0] MARK_NONE = 2'd0;
	localparam logic [1:0] MARK_VISITED = 2'd1;
	localparam logic [1:0] MARK_DONE = 2'd2;

	// Front end classification of one word.
	typedef enum logic [1:0] {
		CMD_SCAN = 2'd0,
		CMD_POP = 2'd1,
		CMD_FIXED = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		status_t fixed_status;
		logic [3:0] walls;
	} cmd_t;

	typedef struct packed {
		logic [2:0] status;
		logic moved;
		logic [1:0] heading;
		logic [3:0] pos_x;
		logic [3:0] pos_y;
	} result_t;

	// Back end state machine.
	typedef enum logic [3:0] {
		BE_IDLE,
		BE_SCAN_RD,
		BE_SCAN_WAIT,
		BE_SCAN_CHK,
		BE_POP_RD,
		BE_POP_WAIT,
		BE_POP_CELL,
		BE_POP_WWAIT,
		BE_POP_CHK,
		BE_OUT
	} be_state_t;

	function automatic logic [2:0] open_count(input logic [3:0] walls);
		return 3'(!walls[0]) + 3'(!walls[1]) + 3'(!walls[2]) + 3'(!walls[3]);
	endfunction

endpackage

>>> sv/mde_if.sv
// Valid/ready channel interface that carries one packed word.
// Depends on nothing; the payload type is a parameter.
interface mde_if #(parameter type word_t = logic) ();
	logic valid;
	logic ready;
	word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/mde_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module mde_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> sv/mde_front.sv
// Front end: accepts input words, classifies them by run mode and queues them.
// Depends on mde_pkg.
module mde_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic in_opcode,
	input logic [3:0] in_walls,
	input mde_pkg::mode_t mode,
	input logic cmd_pop,
	output logic cmd_valid,
	output mde_pkg::cmd_t cmd
);
	import mde_pkg::*;

	// Two-entry queue. Mode only changes while the back end runs, and the
	// front takes one word at a time until the back end has drained it, so
	// the mode seen at acceptance is the mode the word will meet.
	cmd_t q_q [2];
	logic [1:0] cnt_q;
	logic rd_q, wr_q;
	logic busy_q;
	cmd_t c;
	logic push;

	always_comb begin
		c.walls = in_walls;
		c.fixed_status = ST_REFUSED;
		case (mode)
			MODE_GOAL: begin
				c.kind = CMD_FIXED;
				c.fixed_status = ST_GOAL;
			end
			MODE_HALT: begin
				c.kind = CMD_FIXED;
				c.fixed_status = ST_EMPTY;
			end
			MODE_EXPLORE: c.kind = in_opcode ? CMD_FIXED : CMD_SCAN;
			default: c.kind = in_opcode ? CMD_POP : CMD_FIXED;
		endcase
	end

	assign in_ready = !busy_q && cnt_q != 2'd2;
	assign push = in_valid && in_ready;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q] <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			busy_q <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (cmd_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
			if (push) begin
				busy_q <= 1'b1;
			end else if (cmd_pop) begin
				busy_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !push) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cnt_q != 2'd0) else $error("queue underflow");
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !in_ready) else $error("second word accepted while busy");
`endif
endmodule

>>> sv/mde_back.sv
// Back end: carries out scans and backtracking steps on the maze memories.
// Depends on mde_pkg and mde_ram.
module mde_back #(
	parameter int MAZE_SIDE = mde_pkg::MAZE_SIDE_DEF,
	parameter int STACK_DEPTH = mde_pkg::STACK_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input mde_pkg::cmd_t cmd,
	output logic cmd_pop,
	output mde_pkg::mode_t mode,
	input logic cfg_we,
	input logic [mde_pkg::CFG_IDX_W-1:0] cfg_idx,
	input logic [mde_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic res_valid,
	input logic res_ready,
	output mde_pkg::result_t res
);
	import mde_pkg::*;

	localparam int CW = $clog2(MAZE_SIDE);
	localparam int CELLS = MAZE_SIDE * MAZE_SIDE;
	localparam int AW = 2 * CW;
	localparam int SW = $clog2(STACK_DEPTH);
	localparam logic [CW-1:0] HALF = CW'(MAZE_SIDE / 2);
	localparam logic [CW-1:0] LAST = CW'(MAZE_SIDE - 1);

	be_state_t st_q, st_d;
	mode_t mode_q;
	logic [CW-1:0] sx_q, sy_q, cx_q, cy_q;
	logic [1:0] sh_q, ch_q;
	logic first_q;
	logic [SW:0] sp_q;
	logic [1:0] step_q;
	logic [3:0] walls_q;
	logic [2:0] stat_q;
	logic moved_q;
	logic [CELLS-1:0] vis_valid_q;

	logic wm_we, vm_we, ps_we;
	logic [AW-1:0] wm_addr, vm_waddr, vm_raddr;
	logic [3:0] wm_rdata;
	logic [1:0] vm_wdata, vm_rdata;
	logic [SW-1:0] ps_waddr, ps_raddr;
	logic [AW-1:0] ps_rdata;
	logic [1:0] vmark;

	logic [1:0] dir;
	logic nb_ok;
	logic [CW-1:0] nx, ny;
	logic [AW-1:0] here, ncell;
	logic goal_here, goal_n;
	logic [CW-1:0] px, py;

	assign here = {cy_q, cx_q};
	assign px = ps_rdata[CW-1:0];
	assign py = ps_rdata[AW-1:CW];

	always_comb begin
		dir = (st_q == BE_POP_CHK || st_q == BE_POP_WWAIT) ? step_q
			: ch_q + 2'd3 + step_q;
		nx = cx_q;
		ny = cy_q;
		nb_ok = 1'b1;
		case (dir)
			2'd0: begin
				nb_ok = cy_q != '0;
				ny = cy_q - 1'b1;
			end
			2'd1: begin
				nb_ok = cx_q != LAST;
				nx = cx_q + 1'b1;
			end
			2'd2: begin
				nb_ok = cy_q != LAST;
				ny = cy_q + 1'b1;
			end
			default: begin
				nb_ok = cx_q != '0;
				nx = cx_q - 1'b1;
			end
		endcase
		ncell = {ny, nx};
		goal_n = (nx == HALF || nx == HALF - 1'b1) && (ny == HALF || ny == HALF - 1'b1);
		goal_here = (cx_q == HALF || cx_q == HALF - 1'b1)
			&& (cy_q == HALF || cy_q == HALF - 1'b1);
	end

	mde_ram #(.WIDTH(4), .DEPTH(CELLS)) u_walls (
		.clk(clk), .we(wm_we), .waddr(here), .wdata(cmd.walls),
		.raddr(wm_addr), .rdata(wm_rdata));
	mde_ram #(.WIDTH(2), .DEPTH(CELLS)) u_marks (
		.clk(clk), .we(vm_we), .waddr(vm_waddr), .wdata(vm_wdata),
		.raddr(vm_raddr), .rdata(vm_rdata));
	mde_ram #(.WIDTH(AW), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(ps_we), .waddr(ps_waddr), .wdata(here),
		.raddr(ps_raddr), .rdata(ps_rdata));

	assign wm_addr = here;
	assign ps_waddr = sp_q[SW-1:0];
	assign ps_raddr = SW'(sp_q - 1'b1);
	// Registered read data of the marks is only valid for entries written
	// since reset; the rest read as unvisited.
	logic [AW-1:0] vm_raddr_q;
	always_ff @(posedge clk) vm_raddr_q <= vm_raddr;
	assign vmark = vis_valid_q[vm_raddr_q] ? vm_rdata : MARK_NONE;

	// Next state.
	always_comb begin
		st_d = st_q;
		case (st_q)
			BE_IDLE: begin
				if (cmd_valid) begin
					case (cmd.kind)
						CMD_SCAN: st_d = BE_SCAN_RD;
						CMD_POP: st_d = (sp_q == '0) ? BE_OUT : BE_POP_RD;
						default: st_d = BE_OUT;
					endcase
				end
			end
			BE_SCAN_RD: st_d = BE_SCAN_WAIT;
			BE_SCAN_WAIT: st_d = BE_SCAN_CHK;
			BE_SCAN_CHK: begin
				if (!walls_q[dir] && nb_ok && vmark == MARK_NONE) begin
					st_d = BE_OUT;
				end else if (step_q == 2'd2) begin
					st_d = BE_OUT;
				end else begin
					st_d = BE_SCAN_WAIT;
				end
			end
			BE_POP_RD: st_d = BE_POP_WAIT;
			BE_POP_WAIT: st_d = BE_POP_CELL;
			BE_POP_CELL: st_d = BE_POP_WWAIT;
			BE_POP_WWAIT: st_d = BE_POP_CHK;
			BE_POP_CHK: begin
				if (!walls_q[dir] && nb_ok && vmark == MARK_NONE) begin
					st_d = BE_OUT;
				end else if (step_q == 2'd3) begin
					st_d = BE_OUT;
				end else begin
					st_d = BE_POP_WWAIT;
				end
			end
			BE_OUT: if (res_ready) st_d = BE_IDLE;
			default: st_d = BE_IDLE;
		endcase
	end

	// Memory controls.
	always_comb begin
		wm_we = 1'b0;
		vm_we = 1'b0;
		ps_we = 1'b0;
		vm_waddr = here;
		vm_wdata = MARK_DONE;
		vm_raddr = ncell;
		case (st_q)
			BE_SCAN_RD: begin
				wm_we = 1'b1;
				vm_wdata = (first_q && open_count(cmd.walls) == 3'd1) ? MARK_DONE
					: MARK_VISITED;
				vm_we = first_q
					|| (open_count(cmd.walls) == 3'd2 && here != '0);
				if (open_count(cmd.walls) == 3'd2 && here != '0) begin
					vm_wdata = MARK_DONE;
				end
			end
			BE_SCAN_CHK: begin
				if (!walls_q[dir] && nb_ok && vmark == MARK_NONE
						&& sp_q < (SW+1)'(STACK_DEPTH)) begin
					ps_we = 1'b1;
					vm_we = 1'b1;
					vm_waddr = ncell;
					vm_wdata = MARK_VISITED;
				end
			end
			BE_POP_CHK: begin
				if (step_q == 2'd3 && !(!walls_q[dir] && nb_ok && vmark == MARK_NONE)) begin
					vm_we = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		cmd_pop = st_q == BE_OUT && res_ready;
		res_valid = st_q == BE_OUT;
		res.status = stat_q;
		res.moved = moved_q;
		res.heading = ch_q;
		res.pos_x = 4'(cx_q);
		res.pos_y = 4'(cy_q);
	end
	assign mode = mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BE_IDLE;
			mode_q <= MODE_EXPLORE;
			sx_q <= '0;
			sy_q <= '0;
			sh_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
			ch_q <= '0;
			first_q <= 1'b1;
			sp_q <= '0;
			step_q <= '0;
			walls_q <= '0;
			stat_q <= '0;
			moved_q <= 1'b0;
			vis_valid_q <= '0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				case (cfg_idx)
					REG_START_X: begin
						sx_q <= (cfg_data > 4'(LAST)) ? LAST : CW'(cfg_data);
						if (first_q) cx_q <= (cfg_data > 4'(LAST)) ? LAST : CW'(cfg_data);
					end
					REG_START_Y: begin
						sy_q <= (cfg_data > 4'(LAST)) ? LAST : CW'(cfg_data);
						if (first_q) cy_q <= (cfg_data > 4'(LAST)) ? LAST : CW'(cfg_data);
					end
					REG_START_HEADING: begin
						sh_q <= cfg_data[1:0];
						if (first_q) ch_q <= cfg_data[1:0];
					end
					default: ;
				endcase
			end
			if (vm_we) vis_valid_q[vm_waddr] <= 1'b1;
			case (st_q)
				BE_IDLE: begin
					step_q <= '0;
					moved_q <= 1'b0;
					walls_q <= cmd.walls;
					stat_q <= (cmd.kind == CMD_FIXED) ? cmd.fixed_status : ST_EMPTY;
					if (cmd_valid && cmd.kind == CMD_POP && sp_q == '0) begin
						mode_q <= MODE_HALT;
					end
				end
				BE_SCAN_RD: first_q <= 1'b0;
				BE_SCAN_CHK: begin
					step_q <= step_q + 2'd1;
					if (!walls_q[dir] && nb_ok && vmark == MARK_NONE) begin
						if (sp_q >= (SW+1)'(STACK_DEPTH)) begin
							stat_q <= ST_REFUSED;
						end else begin
							sp_q <= sp_q + 1'b1;
							ch_q <= dir;
							cx_q <= nx;
							cy_q <= ny;
							moved_q <= 1'b1;
							stat_q <= goal_n ? ST_GOAL : ST_MOVE;
							if (goal_n) mode_q <= MODE_GOAL;
						end
					end else if (step_q == 2'd2) begin
						stat_q <= ST_DEAD;
						mode_q <= MODE_BACK;
					end
				end
				BE_POP_RD: sp_q <= sp_q - 1'b1;
				BE_POP_WAIT: begin
					if (py < cy_q) ch_q <= 2'd0;
					else if (px > cx_q) ch_q <= 2'd1;
					else if (py > cy_q) ch_q <= 2'd2;
					else if (px < cx_q) ch_q <= 2'd3;
					cx_q <= px;
					cy_q <= py;
					moved_q <= 1'b1;
				end
				BE_POP_WWAIT: walls_q <= wm_rdata;
				BE_POP_CHK: begin
					step_q <= step_q + 2'd1;
					if (!walls_q[dir] && nb_ok && vmark == MARK_NONE) begin
						stat_q <= goal_here ? ST_GOAL : ST_BACK_END;
						mode_q <= goal_here ? MODE_GOAL : MODE_EXPLORE;
					end else if (step_q == 2'd3) begin
						stat_q <= ST_BACK_ON;
					end
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= (SW+1)'(STACK_DEPTH)) else $error("stack pointer out of range");
	a_push_moves: assert property (@(posedge clk) disable iff (!arst_n)
		ps_we |=> moved_q) else $error("push without a move");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(stat_q))
		else $error("result dropped");
`endif
endmodule

>>> sv/maze_dfs_explorer.sv
// Top level of the depth-first maze explorer.
// Depends on mde_pkg, mde_if, mde_front, mde_back and mde_ram.
//
// Channel   Dir  Payload
// -------   ---  -----------------------------------------------
// in_ch     in   opcode, wall_north, wall_east, wall_south, wall_west
// out_ch    out  status, moved, heading, pos_x, pos_y
// cfg       in   cfg_we, cfg_idx, cfg_data (start_x, start_y, start_heading)
//
// A wall report passes through the scan read, wait and check states; the
// back end checks one candidate direction at a time through the registered
// read port of the visit mark memory. A backtracking step is made of the
// stack read, the wall read and up to four mark reads; any other word goes
// straight from the idle state to the output state.
// Reset is asynchronous; the visit marks read as unvisited until written,
// tracked with one valid flop per cell, so no clearing pass is needed.
// One word is in flight at a time; the result waits in the back end while
// the output is stalled, and the input is held off until it is taken.
module maze_dfs_explorer #(
	parameter int MAZE_SIDE = mde_pkg::MAZE_SIDE_DEF,
	parameter int STACK_DEPTH = mde_pkg::STACK_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	mde_if.sink in_ch,
	mde_if.source out_ch,
	input logic cfg_we,
	input logic [mde_pkg::CFG_IDX_W-1:0] cfg_idx,
	input logic [mde_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mde_pkg::*;

	logic cmd_valid, cmd_pop;
	cmd_t cmd;
	mode_t mode;
	result_t res;

	// The input word is packed as {opcode, west, south, east, north}.
	mde_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_opcode(in_ch.data[4]), .in_walls(in_ch.data[3:0]),
		.mode(mode), .cmd_pop(cmd_pop), .cmd_valid(cmd_valid), .cmd(cmd));

	mde_back #(.MAZE_SIDE(MAZE_SIDE), .STACK_DEPTH(STACK_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop), .mode(mode),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(res));

	assign out_ch.data = res;
endmodule
